[hdl/rdv_pkg.sv]
package rdv_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_MDAY  = 2'd2;

   // Stage 1 to stage 2 payload
   typedef struct packed {
      logic [1:0] status;
      logic [6:0] seconds_bcd;
      logic [6:0] minutes_bcd;
      logic [5:0] hours_bcd;
      logic [5:0] mday_bcd;
      logic [4:0] month_bcd;
      logic [7:0] year_bcd;
      logic [5:0] mday_part;   // day + month offset + leap day, weekday terms
      logic [7:0] year_part;   // year terms plus epoch offset
   } stage_type;

   // Packed BCD of a value below 100; tens digit by reciprocal multiply
   function automatic logic [7:0] to_bcd(input logic [6:0] value);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(value) * 15'd205;
      tens = prod[14:11];
      ones = value - 7'(7'(tens) * 7'd10);
      return {tens, ones[3:0]};
   endfunction

   // Days in a month, non-leap February
   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] days;
      unique case (month)
         4'd2:                      days = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
         default:                   days = 5'd31;
      endcase
      return days;
   endfunction

   // Days before the first of the month, modulo 7
   function automatic logic [2:0] month_offset(input logic [3:0] month);
      logic [2:0] offset;
      unique case (month)
         4'd2, 4'd3, 4'd11: offset = 3'd3;
         4'd4, 4'd7:        offset = 3'd6;
         4'd5:              offset = 3'd1;
         4'd6:              offset = 3'd4;
         4'd8:              offset = 3'd2;
         4'd9, 4'd12:       offset = 3'd5;
         default:           offset = 3'd0;
      endcase
      return offset;
   endfunction

   // Modulo 7 of a byte: fold by 64 and by 8 (both 1 mod 7), then trim
   function automatic logic [2:0] mod7(input logic [7:0] value);
      logic [6:0] fold1;
      logic [3:0] fold2;
      logic [3:0] rem;
      fold1 = 7'(value[5:0]) + 7'(value[7:6]);
      fold2 = 4'(fold1[2:0]) + 4'(fold1[6:3]);
      if (fold2 >= 4'd14) begin
         rem = fold2 - 4'd14;
      end else if (fold2 >= 4'd7) begin
         rem = fold2 - 4'd7;
      end else begin
         rem = fold2;
      end
      return rem[2:0];
   endfunction

endpackage

[hdl/rdv_decode.sv]
module rdv_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          seconds,
   input  logic [7:0]          minutes,
   input  logic [7:0]          hours,
   input  logic [7:0]          day_of_month,
   input  logic [7:0]          month,
   input  logic [7:0]          year,
   output logic                out_valid,
   output rdv_pkg::stage_type  out_data
);
   import rdv_pkg::*;

   logic       valid_ff;
   stage_type  data_ff;
   stage_type  data_in;
   logic       range_bad;
   logic       leap_year;
   logic [4:0] mday_limit;
   logic       leap_adj;
   logic [7:0] year_quarter;

   // Range checks and month length check
   always_comb begin
      range_bad = (seconds > 8'd59) || (minutes > 8'd59) || (hours > 8'd23) ||
                  (day_of_month == 8'd0) || (day_of_month > 8'd31) ||
                  (month == 8'd0) || (month > 8'd12) || (year > 8'd99);
      leap_year = (year[1:0] == 2'b00);
      mday_limit = ((month[3:0] == 4'd2) && leap_year) ? 5'd29 : month_days(month[3:0]);
      leap_adj = (month[3:0] > 4'd2) && leap_year;
      year_quarter = 8'((9'(year[6:0]) + 9'd3) >> 2);
   end

   // Stage 1 payload: status, BCD fields, weekday partial sums
   always_comb begin
      data_in = '0;
      if (range_bad) begin
         data_in.status = STATUS_RANGE;
      end else if (day_of_month[4:0] > mday_limit) begin
         data_in.status = STATUS_MDAY;
      end else begin
         data_in.status = STATUS_OK;
      end
      data_in.seconds_bcd = 7'(to_bcd(seconds[6:0]));
      data_in.minutes_bcd = 7'(to_bcd(minutes[6:0]));
      data_in.hours_bcd   = 6'(to_bcd(hours[6:0]));
      data_in.mday_bcd    = 6'(to_bcd(day_of_month[6:0]));
      data_in.month_bcd   = 5'(to_bcd(month[6:0]));
      data_in.year_bcd    = to_bcd(year[6:0]);
      data_in.mday_part   = 6'(day_of_month[4:0]) + 6'(month_offset(month[3:0])) +
                            6'(leap_adj);
      // 365 is 1 mod 7; epoch Saturday folds into +5
      data_in.year_part   = {1'b0, year[6:0]} + year_quarter + 8'd5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hdl/rdv_wday.sv]
module rdv_wday (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rdv_pkg::stage_type  in_data,
   output logic                out_valid,
   output logic [1:0]          status,
   output logic [6:0]          seconds_bcd,
   output logic [6:0]          minutes_bcd,
   output logic [5:0]          hours_bcd,
   output logic [2:0]          weekday,
   output logic [5:0]          mday_bcd,
   output logic [4:0]          month_bcd,
   output logic [7:0]          year_bcd
);
   import rdv_pkg::*;

   // Stage 2: day count sum
   logic       valid2_ff;
   stage_type  data2_ff;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;

   // Stage 3: weekday and error masking
   logic       valid3_ff;
   logic [1:0] status_ff;
   logic [6:0] seconds_ff;
   logic [6:0] minutes_ff;
   logic [5:0] hours_ff;
   logic [2:0] weekday_ff;
   logic [5:0] mday_ff;
   logic [4:0] month_ff;
   logic [7:0] year_ff;
   logic       ok;

   assign sum_in = 8'(in_data.mday_part) + in_data.year_part;
   assign ok     = (data2_ff.status == STATUS_OK);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid2_ff <= in_valid;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      data2_ff   <= in_data;
      sum_ff     <= sum_in;
      status_ff  <= data2_ff.status;
      seconds_ff <= ok ? data2_ff.seconds_bcd : '0;
      minutes_ff <= ok ? data2_ff.minutes_bcd : '0;
      hours_ff   <= ok ? data2_ff.hours_bcd : '0;
      weekday_ff <= ok ? mod7(sum_ff) : '0;
      mday_ff    <= ok ? data2_ff.mday_bcd : '0;
      month_ff   <= ok ? data2_ff.month_bcd : '0;
      year_ff    <= ok ? data2_ff.year_bcd : '0;
   end

   assign out_valid   = valid3_ff;
   assign status      = status_ff;
   assign seconds_bcd = seconds_ff;
   assign minutes_bcd = minutes_ff;
   assign hours_bcd   = hours_ff;
   assign weekday     = weekday_ff;
   assign mday_bcd    = mday_ff;
   assign month_bcd   = month_ff;
   assign year_bcd    = year_ff;

endmodule

[hdl/rtc_date_validate_bcd_encode.sv]
// Date check and BCD register encoder for years 2000 to 2099. Pulse start
// with a date and time on the req_ ports; busy never rises, so a new date
// can be given on every clock. Each accepted date produces exactly one
// result, shown for one cycle with rsp_strobe high; the receiver must
// take it then. The result passes three pipeline registers (decode and
// range check, day-count sum, weekday modulo and masking).
// rsp_status is 0 for a good date, 1 when a field is out of range, 2 when
// the day is past the end of its month; on any error all BCD fields and
// the weekday read 0. Weekday is 0 for Sunday through 6 for Saturday.
module rtc_date_validate_bcd_encode (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_seconds,
   input  logic [7:0] req_minutes,
   input  logic [7:0] req_hours,
   input  logic [7:0] req_day_of_month,
   input  logic [7:0] req_month,
   input  logic [7:0] req_year,
   output logic       rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_seconds_bcd,
   output logic [6:0] rsp_minutes_bcd,
   output logic [5:0] rsp_hours_bcd,
   output logic [2:0] rsp_weekday,
   output logic [5:0] rsp_mday_bcd,
   output logic [4:0] rsp_month_bcd,
   output logic [7:0] rsp_year_bcd
);
   import rdv_pkg::*;

   logic      accept;
   logic      s1_valid;
   stage_type s1_data;

   // Fully pipelined: never busy
   assign busy   = 1'b0;
   assign accept = start && !busy;

   rdv_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .seconds      (req_seconds),
      .minutes      (req_minutes),
      .hours        (req_hours),
      .day_of_month (req_day_of_month),
      .month        (req_month),
      .year         (req_year),
      .out_valid    (s1_valid),
      .out_data     (s1_data)
   );

   rdv_wday u_wday (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_data     (s1_data),
      .out_valid   (rsp_strobe),
      .status      (rsp_status),
      .seconds_bcd (rsp_seconds_bcd),
      .minutes_bcd (rsp_minutes_bcd),
      .hours_bcd   (rsp_hours_bcd),
      .weekday     (rsp_weekday),
      .mday_bcd    (rsp_mday_bcd),
      .month_bcd   (rsp_month_bcd),
      .year_bcd    (rsp_year_bcd)
   );

   // Every transfer in gives one result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("missing result for accepted request");

   // No result without an earlier request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result without request");

   // Errors give zeroed fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |->
         (rsp_seconds_bcd == '0) && (rsp_minutes_bcd == '0) && (rsp_hours_bcd == '0) &&
         (rsp_weekday == '0) && (rsp_mday_bcd == '0) && (rsp_month_bcd == '0) &&
         (rsp_year_bcd == '0))
      else $error("nonzero fields on error status");

   // Weekday stays in range
   a_weekday: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_weekday <= 3'd6))
      else $error("weekday out of range");

endmodule
